[rtl/wsd_pkg.sv]
// Package: shared constants, parser stage type and queue entry type of the WebSocket deframer.
`default_nettype none
package wsd_pkg;

	// Width of the payload length counter.
	localparam int unsigned LEN_BITS = 64;

	// Length codes of the second header byte that announce an extended length.
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// Bytes of extended length and of mask key, less one.
	localparam logic [2:0] EXT16_LAST = 3'd1;
	localparam logic [2:0] EXT64_LAST = 3'd7;
	localparam logic [2:0] KEY_LAST   = 3'd3;

	// Parser stages.
	typedef enum logic [2:0] {
		ST_HDR0    = 3'd0,
		ST_HDR1    = 3'd1,
		ST_EXTLEN  = 3'd2,
		ST_MASK    = 3'd3,
		ST_PAYLOAD = 3'd4
	} stage_t;

	// One classified byte on its way from the parser to the output stage.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
		logic       empty;
	} entry_t;

endpackage
`default_nettype wire

[rtl/wsd_in_if.sv]
// Interface: input channel carrying one received stream byte per request.
`default_nettype none
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[rtl/wsd_out_if.sv]
// Interface: output channel carrying one unmasked payload result per request.
`default_nettype none
interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [3:0] opcode;
	logic       fin;
	logic       last_of_frame;
	logic       empty_frame;

	modport source (output valid, output data_byte, output opcode, output fin,
		output last_of_frame, output empty_frame, input ready);
	modport sink (input valid, input data_byte, input opcode, input fin,
		input last_of_frame, input empty_frame, output ready);
endinterface
`default_nettype wire

[rtl/wsd_front.sv]
// Module: header parser that classifies each received byte and queues payload and empty-frame results.
`default_nettype none
module wsd_front
	import wsd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire logic [7:0] in_byte,
	output logic        in_ready,
	input  wire logic   q_full,
	output logic        q_push,
	output entry_t      q_entry
);

	stage_t                stage_q, stage_d;
	logic                  fin_q, fin_d;
	logic [3:0]            opcode_q, opcode_d;
	logic                  masked_q, masked_d;
	logic                  len16_q, len16_d;
	logic [LEN_BITS-1:0]   rem_q, rem_d;
	logic [2:0]            cnt_q, cnt_d;
	logic [3:0][7:0]       key_q, key_d;
	logic [1:0]            kidx_q, kidx_d;

	logic                  accept;
	logic [LEN_BITS-1:0]   len_shift;
	logic [LEN_BITS-1:0]   rem_dec;
	logic                  ext_done;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// Extended length shifts in big-endian, saturating when it would overflow.
	always_comb begin
		if (rem_q[LEN_BITS-1 -: 8] != 8'd0) begin
			len_shift = '1;
		end else begin
			len_shift = {rem_q[LEN_BITS-9:0], in_byte};
		end
	end

	assign rem_dec  = rem_q - LEN_BITS'(1);
	assign ext_done = len16_q ? (cnt_q == EXT16_LAST) : (cnt_q == EXT64_LAST);

	// Parser next state and queue entry.
	always_comb begin
		stage_d  = stage_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		len16_d  = len16_q;
		rem_d    = rem_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		kidx_d   = kidx_q;
		q_push   = 1'b0;
		q_entry  = '{data: 8'd0, key: 8'd0, opcode: opcode_q, fin: fin_q,
			last: 1'b1, empty: 1'b1};
		if (accept) begin
			case (stage_q)
				ST_HDR1: begin
					masked_d = in_byte[7];
					len16_d  = (in_byte[6:0] == LEN_CODE_16);
					cnt_d    = 3'd0;
					if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
						rem_d   = '0;
						stage_d = ST_EXTLEN;
					end else begin
						rem_d = LEN_BITS'(in_byte[6:0]);
						if (in_byte[7]) begin
							stage_d = ST_MASK;
						end else begin
							kidx_d = 2'd0;
							if (in_byte[6:0] == 7'd0) begin
								stage_d = ST_HDR0;
								q_push  = 1'b1;
							end else begin
								stage_d = ST_PAYLOAD;
							end
						end
					end
				end
				ST_EXTLEN: begin
					rem_d = len_shift;
					if (ext_done) begin
						cnt_d = 3'd0;
						if (masked_q) begin
							stage_d = ST_MASK;
						end else begin
							kidx_d = 2'd0;
							if (len_shift == '0) begin
								stage_d = ST_HDR0;
								q_push  = 1'b1;
							end else begin
								stage_d = ST_PAYLOAD;
							end
						end
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
				ST_MASK: begin
					key_d = {key_q[2:0], in_byte};
					if (cnt_q >= KEY_LAST) begin
						kidx_d = 2'd0;
						if (rem_q == '0) begin
							stage_d = ST_HDR0;
							q_push  = 1'b1;
						end else begin
							stage_d = ST_PAYLOAD;
						end
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
				ST_PAYLOAD: begin
					kidx_d       = kidx_q + 2'd1;
					rem_d        = rem_dec;
					q_push       = 1'b1;
					q_entry.data = in_byte;
					q_entry.key  = masked_q ? key_q[2'd3 - kidx_q] : 8'd0;
					q_entry.last = (rem_dec == '0);
					q_entry.empty = 1'b0;
					if (rem_dec == '0) begin
						stage_d = ST_HDR0;
					end
				end
				default: begin
					fin_d    = in_byte[7];
					opcode_d = in_byte[3:0];
					stage_d  = ST_HDR1;
				end
			endcase
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			len16_q  <= 1'b0;
			rem_q    <= '0;
			cnt_q    <= 3'd0;
			key_q    <= '0;
			kidx_q   <= 2'd0;
		end else begin
			stage_q  <= stage_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			len16_q  <= len16_d;
			rem_q    <= rem_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
		end
	end

endmodule
`default_nettype wire

[rtl/wsd_fifo.sv]
// Module: two-entry queue between the header parser and the output stage.
`default_nettype none
module wsd_fifo
	import wsd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        full,
	input  wire logic   pop,
	output entry_t      pop_entry,
	output logic        not_empty
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/wsd_back.sv]
// Module: output stage that unmasks queued payload bytes into the result register.
`default_nettype none
module wsd_back
	import wsd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_not_empty,
	input  wire entry_t q_entry,
	output logic        q_pop,
	wsd_out_if.source   tx
);

	logic       valid_q;
	logic [7:0] data_q;
	logic [3:0] opcode_q;
	logic       fin_q;
	logic       last_q;
	logic       empty_q;

	// Take the next entry when the result register is free or being emptied.
	assign q_pop = q_not_empty && (!valid_q || tx.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload, unmasked on load.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q   <= q_entry.data ^ q_entry.key;
			opcode_q <= q_entry.opcode;
			fin_q    <= q_entry.fin;
			last_q   <= q_entry.last;
			empty_q  <= q_entry.empty;
		end
	end

	assign tx.valid         = valid_q;
	assign tx.data_byte     = data_q;
	assign tx.opcode        = opcode_q;
	assign tx.fin           = fin_q;
	assign tx.last_of_frame = last_q;
	assign tx.empty_frame   = empty_q;

endmodule
`default_nettype wire

[rtl/websocket_frame_deframer_core.sv]
// Top level: WebSocket receive deframer taking one stream byte per cycle while not stalled.
// Throughput: one byte per cycle unless the queue is full; header bytes give no result.
// Path: a payload or empty-frame result is written into the parser-to-output queue at
// the edge that accepts its byte, then loaded into the result register when it frees;
// input stalls while the queue holds two requests, as when the output is held.
// Reset: asynchronous, clears the parser, empties the queue and drops the result.
`default_nettype none
module websocket_frame_deframer_core
	import wsd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	wsd_in_if.sink    rx,
	wsd_out_if.source tx
);

	logic   q_full;
	logic   q_push;
	entry_t q_push_entry;
	logic   q_pop;
	entry_t q_pop_entry;
	logic   q_not_empty;
	logic   rx_ready;

	assign rx.ready = rx_ready;

	// Header parser.
	wsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (rx_ready),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_push_entry)
	);

	// Queue between parser and output stage.
	wsd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_pop_entry),
		.not_empty  (q_not_empty)
	);

	// Unmasking and result register.
	wsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (q_pop_entry),
		.q_pop       (q_pop),
		.tx          (tx)
	);

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for the WebSocket frame deframer: frame stimulus, predictor and scoreboard.
`default_nettype none
module tb_top;
	import wsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BYTE_TARGET = 1650;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	// How the payload length of a frame is encoded in its header.
	typedef enum logic [1:0] {
		LEN_FORM_SHORT = 2'd0,
		LEN_FORM_16    = 2'd1,
		LEN_FORM_64    = 2'd2
	} len_form_t;

	// Receiver behaviour, redrawn whenever the phase counter wraps.
	typedef enum logic [1:0] {
		RX_ALWAYS  = 2'd0,
		RX_RANDOM  = 2'd1,
		RX_PATTERN = 2'd2,
		RX_SPARSE  = 2'd3
	} sink_mode_t;

	// One payload or empty-frame result as seen on the output channel.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] opcode;
		logic       fin;
		logic       last_of_frame;
		logic       empty_frame;
	} payload_result_t;

	// Frame parser mirror and the queue of payload results it predicts.
	class frame_scoreboard;
		stage_t              stage;
		logic                fin_bit;
		logic [3:0]          frame_op;
		logic                masked;
		logic [6:0]          len_code;
		logic [LEN_BITS-1:0] bytes_left;
		logic [2:0]          count;
		logic [31:0]         key;
		logic [1:0]          key_pos;
		payload_result_t     expected_q[$];
		int unsigned         mismatches;

		function new();
			stage = ST_HDR0;
			fin_bit = 1'b0;
			frame_op = 4'h0;
			masked = 1'b0;
			len_code = 7'd0;
			bytes_left = '0;
			count = 3'd0;
			key = 32'h0;
			key_pos = 2'd0;
			mismatches = 0;
		endfunction

		// Queue one expected result, tagged with the current frame's opcode and FIN.
		function void push_result(logic [7:0] data, logic last, logic empty);
			payload_result_t r;
			r.data_byte = data;
			r.opcode = frame_op;
			r.fin = fin_bit;
			r.last_of_frame = last;
			r.empty_frame = empty;
			expected_q.push_back(r);
		endfunction

		// Header complete: either payload follows or the frame is empty.
		function void header_finished();
			key_pos = 2'd0;
			if (bytes_left == '0) begin
				stage = ST_HDR0;
				push_result(8'h00, 1'b1, 1'b1);
			end else begin
				stage = ST_PAYLOAD;
			end
		endfunction

		// Length known: the mask key comes next on a masked frame.
		function void length_finished();
			count = 3'd0;
			if (masked) begin
				stage = ST_MASK;
			end else begin
				header_finished();
			end
		endfunction

		// Advance the parser by one accepted stream byte.
		function void note_byte(logic [7:0] b);
			logic [2:0] last_count;
			logic [7:0] key_byte;
			case (stage)
				ST_HDR1: begin
					masked = b[7];
					len_code = b[6:0];
					bytes_left = '0;
					count = 3'd0;
					if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
						stage = ST_EXTLEN;
					end else begin
						bytes_left = LEN_BITS'(len_code);
						length_finished();
					end
				end
				ST_EXTLEN: begin
					last_count = (len_code == LEN_CODE_16) ? EXT16_LAST : EXT64_LAST;
					// A length wider than the counter saturates.
					if (bytes_left > (LEN_MAX >> 8)) begin
						bytes_left = LEN_MAX;
					end else begin
						bytes_left = {bytes_left[LEN_BITS-9:0], b};
					end
					if (count >= last_count) begin
						length_finished();
					end else begin
						count = count + 3'd1;
					end
				end
				ST_MASK: begin
					key = {key[23:0], b};
					if (count >= KEY_LAST) begin
						header_finished();
					end else begin
						count = count + 3'd1;
					end
				end
				ST_PAYLOAD: begin
					key_byte = masked ? key[8*(3-key_pos) +: 8] : 8'h00;
					key_pos = key_pos + 2'd1;
					bytes_left = bytes_left - 1'b1;
					if (bytes_left == '0) begin
						stage = ST_HDR0;
					end
					push_result(b ^ key_byte, bytes_left == '0, 1'b0);
				end
				default: begin
					fin_bit = b[7];
					frame_op = b[3:0];
					stage = ST_HDR1;
				end
			endcase
		endfunction

		function void report(string what, payload_result_t want, payload_result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] %s: expected data=%02h op=%0h fin=%0b last=%0b empty=%0b,",
					$realtime, what, want.data_byte, want.opcode, want.fin,
					want.last_of_frame, want.empty_frame);
				$display("    got data=%02h op=%0h fin=%0b last=%0b empty=%0b",
					got.data_byte, got.opcode, got.fin, got.last_of_frame,
					got.empty_frame);
			end
		endfunction

		// Compare an accepted result with the oldest expectation.
		function void check_result(payload_result_t got);
			payload_result_t want;
			if (expected_q.size() == 0) begin
				want = '0;
				report("unexpected result", want, got);
			end else begin
				want = expected_q.pop_front();
				if (got.data_byte !== want.data_byte || got.opcode !== want.opcode ||
					got.fin !== want.fin || got.last_of_frame !== want.last_of_frame ||
					got.empty_frame !== want.empty_frame) begin
					report("result mismatch", want, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wsd_in_if  rx_if ();
	wsd_out_if tx_if ();

	websocket_frame_deframer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	frame_scoreboard sb = new();

	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	logic [7:0]  sink_phase = 8'd0;
	logic [7:0]  sink_mask = 8'hff;
	sink_mode_t  sink_mode = RX_ALWAYS;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		tx_if.ready = 1'b0;
	end

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: ready follows a mode that is redrawn each time the phase counter wraps.
	always @(posedge clk) begin
		sink_phase <= sink_phase + 8'd1;
		if (sink_phase == 8'd0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			sink_mask <= 8'($urandom);
		end
		case (sink_mode)
			RX_ALWAYS:  tx_if.ready <= 1'b1;
			RX_RANDOM:  tx_if.ready <= ($urandom_range(0, 3) != 0);
			RX_PATTERN: tx_if.ready <= sink_mask[sink_phase[2:0]];
			default:    tx_if.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Monitor both channels at the clock edge.
	always @(posedge clk) begin
		payload_result_t got;
		if (arst_n) begin
			if (tx_if.valid && tx_if.ready) begin
				got.data_byte = tx_if.data_byte;
				got.opcode = tx_if.opcode;
				got.fin = tx_if.fin;
				got.last_of_frame = tx_if.last_of_frame;
				got.empty_frame = tx_if.empty_frame;
				sb.check_result(got);
			end
			if (rx_if.valid && rx_if.ready) begin
				sb.note_byte(rx_if.rx_byte);
			end
		end
	end

	// Offer one stream byte and hold it until the request is taken; between bursts, usually idle.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				rx_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		burst_left--;
		bytes_sent++;
	endtask

	// Send a whole frame: header, length, optional key and n_payload random bytes.
	task automatic send_frame(input logic [7:0] hdr0, input logic mask_bit,
		input len_form_t form, input logic [63:0] len, input logic [31:0] key_word,
		input int unsigned n_payload);
		send_byte(hdr0);
		case (form)
			LEN_FORM_16: begin
				send_byte({mask_bit, LEN_CODE_16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			LEN_FORM_64: begin
				send_byte({mask_bit, LEN_CODE_64});
				for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
			end
			default: send_byte({mask_bit, len[6:0]});
		endcase
		if (mask_bit) begin
			for (int i = 3; i >= 0; i--) send_byte(key_word[8*i +: 8]);
		end
		for (int i = 0; i < n_payload; i++) send_byte(8'($urandom));
	endtask

	// Main sequence.
	initial begin
		int unsigned pick;
		int unsigned len;
		logic        mask_bit;
		len_form_t   form;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty unmasked frame.
		send_byte(8'h81);
		send_byte(8'h00);
		// Empty masked frame, all-ones key.
		send_byte(8'h8a);
		send_byte(8'h80);
		repeat (4) send_byte(8'hff);
		// Unmasked payload with extreme byte values.
		send_byte(8'h02);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hff);
		// All header bits set, 16-bit length of one, masked.
		send_byte(8'hff);
		send_byte(8'hfe);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h5a);
		send_byte(8'ha5);
		send_byte(8'hff);
		// Empty frame given through a 16-bit length.
		send_byte(8'h09);
		send_byte(8'h7e);
		send_byte(8'h00);
		send_byte(8'h00);

		// Random frames: mostly short, some extended and some non-minimal encodings.
		while (bytes_sent < BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			mask_bit = 1'($urandom_range(0, 1));
			if (pick < 55) begin
				form = LEN_FORM_SHORT;
				len = $urandom_range(0, 20);
			end else if (pick < 75) begin
				form = LEN_FORM_SHORT;
				len = $urandom_range(21, 125);
			end else if (pick < 85) begin
				form = LEN_FORM_16;
				len = $urandom_range(0, 300);
			end else if (pick < 93) begin
				form = LEN_FORM_64;
				len = $urandom_range(0, 200);
			end else begin
				form = ($urandom_range(0, 1) != 0) ? LEN_FORM_16 : LEN_FORM_64;
				len = $urandom_range(0, 10);
			end
			send_frame(8'($urandom), mask_bit, form, 64'(len), $urandom, len);
		end

		// Finally a frame whose 64-bit length has its top bit set; it never completes.
		send_frame(8'h82, 1'b1, LEN_FORM_64, 64'hffff_ffff_ffff_ffff, $urandom, 24);
		rx_if.valid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/wsd_pkg.sv
rtl/wsd_in_if.sv
rtl/wsd_out_if.sv
rtl/wsd_front.sv
rtl/wsd_fifo.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer_core.sv
bench/tb_top.sv
